// ----- hw/rtl/wv_pkg.sv -----
// Shared types and constants of the sliding-window variance block.
package wv_pkg;

    // Width of the variance result and its saturation value.
    localparam int unsigned OUT_W = 24;
    localparam logic [OUT_W-1:0] RESULT_MAX = 24'hFFFFFF;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_DIV,
        ST_SQ,
        ST_SQ_DIV,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // write the sample, advance the slot, clear pass state
        logic rd_issue;   // read the entry at the pass counter and advance it
        logic sq_mode;    // reads feed the squared deviation pipeline
        logic div_start;  // start a division of the accumulator by the window size
        logic mean_load;  // take the quotient as the mean and restart the pass
        logic out_load;   // take the saturated quotient into the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issued_all; // every entry of the window has been read in this pass
        logic pipe_busy;  // reads or products are still on their way to the accumulator
        logic div_busy;   // the quotient of the started division is not yet registered
    } status_t;

endpackage

// ----- hw/rtl/window_variance.sv -----
// Sliding-window variance of ADC samples: top level.
//
// Each sample transaction on the sample channel (sample_valid / sample_ready)
// writes one sample into a ring of WINDOW entries, overwriting the oldest.
// The block then returns one variance transaction (variance_valid /
// variance_ready): the truncated mean of the squared deviations of the
// window from its truncated mean, saturated to 24 bits.
// One sample is worked on at a time. The result comes from two read passes
// over the ring through its single read port, each followed by a division
// by WINDOW as a reciprocal multiplication.
// The result sits in an output register, so the next sample is accepted
// while an earlier result still waits for the receiver. When the receiver
// stalls, a finished result waits in the controller until that register
// is free, and no new sample is taken meanwhile.
// Reset clears the ring to zero through per-entry valid bits, the write
// position, the controller and the output valid flag.
module window_variance #(
    parameter int unsigned WINDOW      = 8,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      variance_valid,
    input  logic                      variance_ready,
    output logic [wv_pkg::OUT_W-1:0]  variance
);

    wv_pkg::cmd_t    cmd;
    wv_pkg::status_t status;

    // Controller.
    wv_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .variance_valid (variance_valid),
        .variance_ready (variance_ready),
        .status         (status),
        .cmd            (cmd)
    );

    // Datapath.
    wv_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .cmd      (cmd),
        .status   (status),
        .variance (variance)
    );

`ifndef SYNTH
    // After a sample is taken the block is busy with it.
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !sample_ready)
        else $error("sample accepted again right after a load");

    // A division starts only with the accumulator settled and the divider free.
    a_div_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (!status.pipe_busy && !status.div_busy && status.issued_all))
        else $error("division started before the pass had finished");

    // No read past the end of the window.
    a_no_over_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> !status.issued_all)
        else $error("read issued beyond the window");

    // The result is loaded only from a finished division.
    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.div_busy)
        else $error("result loaded while the divider was still stepping");
`endif

endmodule

// ----- hw/rtl/wv_ctrl.sv -----
// Controller state machine of the sliding-window variance block.
module wv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    output logic              variance_valid,
    input  logic              variance_ready,
    input  wv_pkg::status_t   status,
    output wv_pkg::cmd_t      cmd
);

    wv_pkg::state_t state_reg;
    wv_pkg::state_t state_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_free;

    // The result register can take a new value when it is empty or being drained.
    assign out_free = !out_valid_reg || variance_ready;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wv_pkg::ST_IDLE:
            begin
                if (sample_valid)
                    state_next = wv_pkg::ST_SUM;
            end
            wv_pkg::ST_SUM:
            begin
                if (status.issued_all && !status.pipe_busy)
                    state_next = wv_pkg::ST_SUM_DIV;
            end
            wv_pkg::ST_SUM_DIV:
            begin
                if (!status.div_busy)
                    state_next = wv_pkg::ST_SQ;
            end
            wv_pkg::ST_SQ:
            begin
                if (status.issued_all && !status.pipe_busy)
                    state_next = wv_pkg::ST_SQ_DIV;
            end
            wv_pkg::ST_SQ_DIV:
            begin
                if (!status.div_busy)
                    state_next = wv_pkg::ST_DONE;
            end
            wv_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = wv_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wv_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: datapath commands and handshake signals.
    always_comb
    begin
        cmd            = '0;
        sample_ready   = 1'b0;
        out_valid_next = out_valid_reg && !variance_ready;
        case (state_reg)
            wv_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.load     = sample_valid;
            end
            wv_pkg::ST_SUM:
            begin
                cmd.rd_issue  = !status.issued_all;
                cmd.div_start = status.issued_all && !status.pipe_busy;
            end
            wv_pkg::ST_SUM_DIV:
            begin
                cmd.mean_load = !status.div_busy;
            end
            wv_pkg::ST_SQ:
            begin
                cmd.sq_mode   = 1'b1;
                cmd.rd_issue  = !status.issued_all;
                cmd.div_start = status.issued_all && !status.pipe_busy;
            end
            wv_pkg::ST_SQ_DIV:
            begin
                cmd.sq_mode = 1'b1;
            end
            wv_pkg::ST_DONE:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign variance_valid = out_valid_reg;

endmodule

// ----- hw/rtl/wv_datapath.sv -----
// Datapath of the sliding-window variance block: sample ring, accumulator and divider.
module wv_datapath #(
    parameter int unsigned WINDOW      = 8,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [SAMPLE_BITS-1:0]     sample,
    input  wv_pkg::cmd_t               cmd,
    output wv_pkg::status_t            status,
    output logic [wv_pkg::OUT_W-1:0]   variance
);

    localparam int unsigned AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW     = $clog2(WINDOW + 1);
    localparam int unsigned LW     = $clog2(WINDOW);
    localparam int unsigned SQ_W   = 2 * SAMPLE_BITS + LW;
    localparam int unsigned PROD_W = 2 * SAMPLE_BITS;
    // Below the saturation limit the squared sum needs no more than SAT_W bits.
    localparam int unsigned SAT_W  = wv_pkg::OUT_W + LW;
    localparam int unsigned DIV_W  = (SQ_W < SAT_W) ? SQ_W : SAT_W;
    localparam int unsigned CMP_W  = ((SQ_W > SAT_W) ? SQ_W : SAT_W) + 1;
    // Reciprocal of the window size, exact for every dividend of DIV_W bits.
    localparam int unsigned RS     = DIV_W + LW;
    localparam int unsigned MW     = DIV_W + 1;
    localparam int unsigned PW     = DIV_W + MW;
    localparam int unsigned QW     = PW - RS;
    localparam int unsigned EXT_W  = (QW > wv_pkg::OUT_W) ? QW : wv_pkg::OUT_W;
    localparam logic [63:0]       RECIP_FULL =
        ((64'd1 << RS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MW-1:0]     RECIP      = RECIP_FULL[MW-1:0];
    localparam logic [CMP_W-1:0]  SAT_LIM    = CMP_W'(WINDOW) << wv_pkg::OUT_W;

    // Sample ring and its per-entry valid bits.
    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [WINDOW-1:0]      valid_reg;
    logic [AW-1:0]          slot_reg;

    // Read pass and pipeline.
    logic [CW-1:0]          cnt_reg;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] mem_q_reg;
    logic                   rd_bit_reg;
    logic                   rd_vld_reg;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [SAMPLE_BITS-1:0] dev_reg;
    logic                   dev_vld_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   prod_vld_reg;
    logic [SQ_W-1:0]        acc_reg;

    // Division by the window size through a reciprocal multiplication.
    logic [CMP_W-1:0]       acc_cmp;
    logic                   acc_over;
    logic [DIV_W-1:0]       dvd_reg;
    logic                   over_reg;
    logic                   div_busy_reg;
    logic [PW-1:0]          recip_prod;
    logic [QW-1:0]          quo_reg;

    // Saturated result.
    logic [EXT_W-1:0]       quo_ext;
    logic [wv_pkg::OUT_W-1:0] var_sat;
    logic [wv_pkg::OUT_W-1:0] var_reg;

    assign rd_addr = cnt_reg[AW-1:0];

    // Ring write: the sample overwrites the oldest entry.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[slot_reg] <= sample;
    end

    // Ring read with registered data.
    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[rd_addr];
    end

    // Entries not written since reset read as zero.
    assign rd_data = rd_bit_reg ? mem_q_reg : '0;

    // Control registers: valid bits, write slot, pass counter, pipeline flags, divider flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            slot_reg     <= '0;
            cnt_reg      <= '0;
            rd_bit_reg   <= 1'b0;
            rd_vld_reg   <= 1'b0;
            dev_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
            if (cmd.load || cmd.mean_load)
                cnt_reg <= '0;
            else if (cmd.rd_issue)
                cnt_reg <= cnt_reg + 1'b1;
            rd_bit_reg   <= valid_reg[rd_addr];
            rd_vld_reg   <= cmd.rd_issue;
            dev_vld_reg  <= rd_vld_reg && cmd.sq_mode;
            prod_vld_reg <= dev_vld_reg;
            div_busy_reg <= cmd.div_start;
        end
    end

    // Deviation from the mean, its square, and the accumulator.
    always_ff @(posedge clk)
    begin
        dev_reg  <= (rd_data >= mean_reg) ? rd_data - mean_reg : mean_reg - rd_data;
        prod_reg <= dev_reg * dev_reg;
        if (cmd.load || cmd.mean_load)
            acc_reg <= '0;
        else if (rd_vld_reg && !cmd.sq_mode)
            acc_reg <= acc_reg + SQ_W'(rd_data);
        else if (prod_vld_reg)
            acc_reg <= acc_reg + SQ_W'(prod_reg);
        if (cmd.mean_load)
            mean_reg <= quo_reg[SAMPLE_BITS-1:0];
    end

    // A sum at or above WINDOW times 2^OUT_W gives a saturated variance.
    assign acc_cmp  = CMP_W'(acc_reg);
    assign acc_over = (acc_cmp >= SAT_LIM);

    // The dividend is registered first, and the quotient in the cycle after.
    assign recip_prod = PW'(dvd_reg) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg  <= acc_reg[DIV_W-1:0];
            over_reg <= acc_over;
        end
        if (div_busy_reg)
            quo_reg <= recip_prod[PW-1:RS];
    end

    // Saturate the variance to the result width and hold it for the receiver.
    assign quo_ext = EXT_W'(quo_reg);
    assign var_sat = over_reg ? wv_pkg::RESULT_MAX : quo_ext[wv_pkg::OUT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            var_reg <= var_sat;
    end

    assign variance          = var_reg;
    assign status.issued_all = (cnt_reg == CW'(WINDOW));
    assign status.pipe_busy  = rd_vld_reg || dev_vld_reg || prod_vld_reg;
    assign status.div_busy   = div_busy_reg;

endmodule
